// ===== design/tda_pkg.sv =====
`timescale 1ns / 1ps

package tda_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [2:0] REQ_LOAD = 3'd0;
  localparam logic [2:0] REQ_INC  = 3'd1;
  localparam logic [2:0] REQ_DEC  = 3'd2;
  localparam logic [2:0] REQ_ADD  = 3'd3;
  localparam logic [2:0] REQ_SUB  = 3'd4;
  localparam logic [2:0] REQ_READ = 3'd5;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;
  localparam logic [5:0] SECS_PER_MIN  = 6'd60;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_ADD,
    KIND_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/time_of_day_adjust_unit.sv =====
`timescale 1ns / 1ps

// Time-of-day counter kept as hour, minute and second, wrapping at 24:00:00.
// Requests enter on in_valid / in_stall with req_type and its operands:
// load, add one second, subtract one second, add amount, subtract amount,
// or read. Unused request codes are dropped at the input. Only a read gives
// a result, on out_valid / out_stall with hour_out, minute_out, second_out.
// A six-stage front pipeline reduces each request to a normalized offset or
// load value using reciprocal multiplies on alternate stages; a short queue
// then feeds the back end, which applies one request per cycle with a carry add
// unless a read waits on a stalled output. Throughput is one request per cycle
// when nothing stalls; read results pass the queue into the output register.
// Reset clears the time to 00:00:00 and empties the pipeline and queue.
// When the receiver stalls, the result holds in the output register; later
// loads and adjustments still drain until a second read reaches the back,
// then the queue fills and in_stall rises.
module time_of_day_adjust_unit #(
  parameter int unsigned QUEUE_DEPTH = tda_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [7:0]  load_hour,
  input  logic [7:0]  load_minute,
  input  logic [7:0]  load_second,
  input  logic [19:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);

  tda_pkg::queue_status_t q_status;
  tda_pkg::cmd_t          push_cmd;
  tda_pkg::cmd_t          pop_cmd;
  logic                   push;
  logic                   pop;

  tda_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .load_hour   (load_hour),
    .load_minute (load_minute),
    .load_second (load_second),
    .amount      (amount),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  tda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  tda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hour_out   (hour_out),
    .minute_out (minute_out),
    .second_out (second_out)
  );

endmodule

// ===== design/tda_front.sv =====
`timescale 1ns / 1ps

module tda_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             req_type,
  input  logic [7:0]             load_hour,
  input  logic [7:0]             load_minute,
  input  logic [7:0]             load_second,
  input  logic [19:0]            amount,
  input  tda_pkg::queue_status_t q_status,
  output logic                   push,
  output tda_pkg::cmd_t          push_cmd
);

  // Reciprocals for exact division of the bounded operands used below.
  localparam logic [14:0] DAY_RECIP  = 15'd24856; // x / 675, x < 8192
  localparam logic [12:0] HOUR_RECIP = 13'd4661;  // x / 225, x < 5400
  localparam logic [12:0] MIN_RECIP  = 13'd4370;  // x / 15, x < 1024
  localparam logic [6:0]  DIV3_RECIP = 7'd86;     // x / 3, x < 128
  localparam logic [19:0] DAY_SECS   = 20'd86400;
  localparam logic [16:0] HOUR_SECS  = 17'd3600;

  logic [5:0] v;
  logic       adv;

  logic [2:0]  r0_req;
  logic [19:0] r0_amt;
  logic [7:0]  r0_lh, r0_lm, r0_ls;

  logic [2:0]  r1_req;
  logic [19:0] r1_amt;
  logic [3:0]  r1_q;
  logic [7:0]  r1_lh, r1_lm, r1_ls;
  logic [2:0]  r1_sq;

  logic [2:0]  r2_req;
  logic [16:0] r2_t;
  logic [7:0]  r2_lh;
  logic [8:0]  r2_mm;
  logic [5:0]  r2_sec;

  logic [2:0]  r3_req;
  logic [16:0] r3_t;
  logic [4:0]  r3_h;
  logic [7:0]  r3_lh;
  logic [8:0]  r3_mm;
  logic [2:0]  r3_mq;
  logic [5:0]  r3_sec;

  logic [2:0]  r4_req;
  logic [11:0] r4_rem;
  logic [4:0]  r4_h;
  logic [8:0]  r4_hh;
  logic [5:0]  r4_min;
  logic [5:0]  r4_sec;

  logic [2:0]  r5_req;
  logic [11:0] r5_rem;
  logic [4:0]  r5_h;
  logic [5:0]  r5_m;
  logic [8:0]  r5_hh;
  logic [3:0]  r5_hq;
  logic [5:0]  r5_min;
  logic [5:0]  r5_sec;

  logic [27:0] q_prod;
  logic [22:0] sq_prod;
  logic [19:0] day_rem;
  logic [16:0] t_mod;
  logic [16:0] t1;
  logic [7:0]  sec_full;
  logic [8:0]  mm1;
  logic [25:0] h_prod;
  logic [22:0] mq_prod;
  logic [16:0] rem_full;
  logic [8:0]  min_full;
  logic [8:0]  hh3;
  logic [22:0] m_prod;
  logic [12:0] hq_prod;
  logic [11:0] sec_add_full;
  logic [8:0]  hour_load_full;

  assign in_stall = v[5] && q_status.full;
  assign adv      = !in_stall;
  assign push     = v[5] && !q_status.full;

  always_comb begin
    q_prod  = 28'(r0_amt[19:7]) * 28'(DAY_RECIP);
    sq_prod = 23'(r0_ls[7:2]) * 23'(MIN_RECIP);

    day_rem  = r1_amt - 20'(r1_q) * DAY_SECS;
    t_mod    = day_rem[16:0];
    sec_full = r1_ls - 8'(r1_sq) * 8'(tda_pkg::SECS_PER_MIN);
    mm1      = 9'(r1_lm) + 9'(r1_sq);

    h_prod  = 26'(r2_t[16:4]) * 26'(HOUR_RECIP);
    mq_prod = 23'(r2_mm[8:2]) * 23'(MIN_RECIP);

    rem_full = r3_t - 17'(r3_h) * HOUR_SECS;
    min_full = r3_mm - 9'(r3_mq) * 9'(tda_pkg::MINS_PER_HOUR);
    hh3      = 9'(r3_lh) + 9'(r3_mq);

    m_prod  = 23'(r4_rem[11:2]) * 23'(MIN_RECIP);
    hq_prod = 13'(r4_hh[8:3]) * 13'(DIV3_RECIP);

    sec_add_full   = r5_rem - 12'(r5_m) * 12'(tda_pkg::SECS_PER_MIN);
    hour_load_full = r5_hh - 9'(r5_hq) * 9'(tda_pkg::HOURS_PER_DAY);
  end

  // Every adjustment request becomes a forward offset within one day.
  always_comb begin
    unique case (r1_req)
      tda_pkg::REQ_INC: t1 = 17'd1;
      tda_pkg::REQ_DEC: t1 = DAY_SECS[16:0] - 17'd1;
      tda_pkg::REQ_ADD: t1 = t_mod;
      tda_pkg::REQ_SUB: t1 = (t_mod == 17'd0) ? 17'd0 : DAY_SECS[16:0] - t_mod;
      default:          t1 = 17'd0;
    endcase
  end

  always_comb begin
    push_cmd = '0;
    unique case (r5_req)
      tda_pkg::REQ_LOAD: begin
        push_cmd.kind   = tda_pkg::KIND_LOAD;
        push_cmd.hour   = hour_load_full[4:0];
        push_cmd.minute = r5_min;
        push_cmd.second = r5_sec;
      end
      tda_pkg::REQ_READ: begin
        push_cmd.kind = tda_pkg::KIND_READ;
      end
      default: begin
        push_cmd.kind   = tda_pkg::KIND_ADD;
        push_cmd.hour   = r5_h;
        push_cmd.minute = r5_m;
        push_cmd.second = sec_add_full[5:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4:0], in_valid && (req_type <= tda_pkg::REQ_READ)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_req <= req_type;
      r0_amt <= amount;
      r0_lh  <= load_hour;
      r0_lm  <= load_minute;
      r0_ls  <= load_second;

      r1_req <= r0_req;
      r1_amt <= r0_amt;
      r1_q   <= q_prod[27:24];
      r1_lh  <= r0_lh;
      r1_lm  <= r0_lm;
      r1_ls  <= r0_ls;
      r1_sq  <= sq_prod[18:16];

      r2_req <= r1_req;
      r2_t   <= t1;
      r2_lh  <= r1_lh;
      r2_mm  <= mm1;
      r2_sec <= sec_full[5:0];

      r3_req <= r2_req;
      r3_t   <= r2_t;
      r3_h   <= h_prod[24:20];
      r3_lh  <= r2_lh;
      r3_mm  <= r2_mm;
      r3_mq  <= mq_prod[18:16];
      r3_sec <= r2_sec;

      r4_req <= r3_req;
      r4_rem <= rem_full[11:0];
      r4_h   <= r3_h;
      r4_hh  <= hh3;
      r4_min <= min_full[5:0];
      r4_sec <= r3_sec;

      r5_req <= r4_req;
      r5_rem <= r4_rem;
      r5_h   <= r4_h;
      r5_m   <= m_prod[21:16];
      r5_hh  <= r4_hh;
      r5_hq  <= hq_prod[11:8];
      r5_min <= r4_min;
      r5_sec <= r4_sec;
    end
  end

endmodule

// ===== design/tda_queue.sv =====
`timescale 1ns / 1ps

module tda_queue #(
  parameter int unsigned DEPTH = tda_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tda_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output tda_pkg::cmd_t          pop_cmd,
  output tda_pkg::queue_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tda_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_cmd      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> (!status.full || pop))
    else $error("request pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> !status.empty)
    else $error("request popped from an empty queue");

endmodule

// ===== design/tda_back.sv =====
`timescale 1ns / 1ps

module tda_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tda_pkg::queue_status_t q_status,
  input  tda_pkg::cmd_t          pop_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             hour_out,
  output logic [5:0]             minute_out,
  output logic [5:0]             second_out
);

  logic [4:0] hours, hours_next;
  logic [5:0] minutes, minutes_next;
  logic [5:0] seconds, seconds_next;
  logic       out_free;
  logic       is_read;
  logic [6:0] sec_sum;
  logic [6:0] min_sum;
  logic [5:0] hour_sum;
  logic       sec_carry, min_carry;

  assign out_free = !out_valid || !out_stall;
  assign is_read  = (pop_cmd.kind == tda_pkg::KIND_READ);
  assign pop      = !q_status.empty && (!is_read || out_free);

  // Mixed-radix add; the operands are normalized, so one wrap per digit suffices.
  always_comb begin
    sec_sum   = 7'(seconds) + 7'(pop_cmd.second);
    sec_carry = (sec_sum >= 7'(tda_pkg::SECS_PER_MIN));
    min_sum   = 7'(minutes) + 7'(pop_cmd.minute) + 7'(sec_carry);
    min_carry = (min_sum >= 7'(tda_pkg::MINS_PER_HOUR));
    hour_sum  = 6'(hours) + 6'(pop_cmd.hour) + 6'(min_carry);
  end

  always_comb begin
    hours_next   = hours;
    minutes_next = minutes;
    seconds_next = seconds;
    if (pop) begin
      unique case (pop_cmd.kind)
        tda_pkg::KIND_LOAD: begin
          hours_next   = pop_cmd.hour;
          minutes_next = pop_cmd.minute;
          seconds_next = pop_cmd.second;
        end
        tda_pkg::KIND_ADD: begin
          seconds_next = sec_carry ? 6'(sec_sum - 7'(tda_pkg::SECS_PER_MIN)) : sec_sum[5:0];
          minutes_next = min_carry ? 6'(min_sum - 7'(tda_pkg::MINS_PER_HOUR)) : min_sum[5:0];
          hours_next   = (hour_sum >= 6'(tda_pkg::HOURS_PER_DAY)) ?
                         5'(hour_sum - 6'(tda_pkg::HOURS_PER_DAY)) : hour_sum[4:0];
        end
        default: begin
          hours_next = hours;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hours     <= '0;
      minutes   <= '0;
      seconds   <= '0;
      out_valid <= 1'b0;
    end else begin
      hours   <= hours_next;
      minutes <= minutes_next;
      seconds <= seconds_next;
      if (out_free) begin
        out_valid <= pop && is_read;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pop && is_read) begin
      hour_out   <= hours;
      minute_out <= minutes;
      second_out <= seconds;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (hours < tda_pkg::HOURS_PER_DAY) && (minutes < tda_pkg::MINS_PER_HOUR) &&
    (seconds < tda_pkg::SECS_PER_MIN))
    else $error("time of day left its normal range");

  assert property (@(posedge clk) disable iff (rst) (pop && is_read) |=> out_valid)
    else $error("read request popped without a result");

endmodule
